// ----- design/qsed_pkg.sv -----
// ----------------------------------------------------------------------------
// qsed_pkg
// Shared types, codes and helpers for the quoted string escape decoder.
// ----------------------------------------------------------------------------
package qsed_pkg;

  // most results one source byte can cause, and result queue depth
  localparam int unsigned MaxRes    = 6;
  localparam int unsigned ResCntW   = 3;
  localparam int unsigned FifoDepth = 16;

  // result kinds
  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindClose = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  // error codes
  localparam logic [3:0] ErrNone      = 4'd0;
  localparam logic [3:0] ErrNotQuote  = 4'd1;
  localparam logic [3:0] ErrUnterm    = 4'd2;
  localparam logic [3:0] ErrRawBreak  = 4'd3;
  localparam logic [3:0] ErrBadEscape = 4'd4;
  localparam logic [3:0] ErrBadHex    = 4'd5;
  localparam logic [3:0] ErrDecRange  = 4'd6;
  localparam logic [3:0] ErrUniForm   = 4'd7;
  localparam logic [3:0] ErrUniRange  = 4'd8;

  // characters with a role in the syntax
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [3:0]  error_code;
    logic [15:0] consumed;
    logic        last;
  } out_item_t;

  // results of one source byte, entries below cnt are used
  typedef struct packed {
    logic [ResCntW-1:0]         cnt;
    out_item_t [MaxRes-1:0]     item;
  } res_bundle_t;

  // hex digit value, msb flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic out_item_t mk_byte(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    r.kind     = KindByte;
    return r;
  endfunction

  function automatic out_item_t mk_close(input logic [15:0] cnt);
    out_item_t r;
    r = '0;
    r.kind     = KindClose;
    r.consumed = cnt;
    return r;
  endfunction

  function automatic out_item_t mk_err(input logic [3:0] code);
    out_item_t r;
    r = '0;
    r.kind       = KindError;
    r.error_code = code;
    return r;
  endfunction

endpackage

// ----- design/qsed_decode.sv -----
// ----------------------------------------------------------------------------
// qsed_decode
// Literal state machine: decodes one source byte per cycle while go_i is high
// into a bundle of up to six results.
// ----------------------------------------------------------------------------
module qsed_decode import qsed_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  in_item_t    item_i,
  output res_bundle_t res_o
);

  localparam int unsigned CntExtW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef enum logic [3:0] {
    ModeIdle, ModeBody, ModeEsc, ModeSkip, ModeHex1,
    ModeHex2, ModeDec, ModeUbrace, ModeUdig
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic                  dquote_q, dquote_d;
  logic [31:0]           esc_val_q, esc_val_d;
  logic [3:0]            dig_cnt_q, dig_cnt_d;
  logic [COUNT_BITS-1:0] byte_cnt_q, byte_cnt_d;

  logic [7:0]            b;
  logic [7:0]            quote;
  logic [4:0]            hx;
  logic [9:0]            dec_val;
  logic [CntExtW-1:0]    cnt_ext;
  logic [2:0]            utf_len;
  logic [7:0]            utf_lead;
  logic                  run_body;
  logic [ResCntW-1:0]    n;
  out_item_t [MaxRes-1:0] res;

  assign b       = item_i.in_byte;
  assign quote   = dquote_q ? ChDquote : ChSquote;
  assign hx      = hex_digit(b);
  assign dec_val = 10'(esc_val_q[6:0]) * 10'd10 + 10'(b - 8'h30);
  assign cnt_ext = CntExtW'(byte_cnt_d);

  // utf-8 length and lead byte of a pending code point
  always_comb begin
    utf_len  = 3'd1;
    utf_lead = esc_val_q[7:0];
    if (esc_val_q > 32'h3ff_ffff) begin
      utf_len  = 3'd6;
      utf_lead = {7'b1111110, esc_val_q[30]};
    end else if (esc_val_q > 32'h1f_ffff) begin
      utf_len  = 3'd5;
      utf_lead = {6'b111110, esc_val_q[25:24]};
    end else if (esc_val_q > 32'hffff) begin
      utf_len  = 3'd4;
      utf_lead = {5'b11110, esc_val_q[20:18]};
    end else if (esc_val_q > 32'h7ff) begin
      utf_len  = 3'd3;
      utf_lead = {4'b1110, esc_val_q[15:12]};
    end else if (esc_val_q > 32'h7f) begin
      utf_len  = 3'd2;
      utf_lead = {3'b110, esc_val_q[10:6]};
    end
  end

  // next state and result bundle
  always_comb begin
    mode_d     = mode_q;
    dquote_d   = dquote_q;
    esc_val_d  = esc_val_q;
    dig_cnt_d  = dig_cnt_q;
    byte_cnt_d = byte_cnt_q;
    run_body   = 1'b0;
    n          = '0;
    res        = '0;
    if (go_i) begin
      if (item_i.start_req) begin
        esc_val_d  = '0;
        dig_cnt_d  = '0;
        byte_cnt_d = '0;
        if (item_i.end_of_data || !(b == ChDquote || b == ChSquote)) begin
          dquote_d = 1'b0;
          res[n]   = mk_err(ErrNotQuote);
          n        = n + 1'b1;
          mode_d   = ModeIdle;
        end else begin
          dquote_d   = (b == ChDquote);
          byte_cnt_d = COUNT_BITS'(1);
          mode_d     = ModeBody;
        end
      end else if (mode_q == ModeIdle) begin
        mode_d = ModeIdle;
      end else if (item_i.end_of_data) begin
        // a pending decimal escape is flushed first
        if (mode_q == ModeDec) begin
          res[n] = mk_byte(esc_val_q[7:0]);
          n      = n + 1'b1;
        end
        res[n] = mk_err(ErrUnterm);
        n      = n + 1'b1;
        mode_d = ModeIdle;
      end else begin
        if (byte_cnt_q != '1) begin
          byte_cnt_d = byte_cnt_q + 1'b1;
        end
        case (mode_q)
          ModeBody: begin
            run_body = 1'b1;
          end
          ModeEsc: begin
            mode_d = ModeBody;
            case (b)
              "a":      begin res[n] = mk_byte(8'd7);  n = n + 1'b1; end
              "b":      begin res[n] = mk_byte(8'd8);  n = n + 1'b1; end
              "f":      begin res[n] = mk_byte(8'd12); n = n + 1'b1; end
              "n":      begin res[n] = mk_byte(8'd10); n = n + 1'b1; end
              "r":      begin res[n] = mk_byte(8'd13); n = n + 1'b1; end
              "t":      begin res[n] = mk_byte(8'd9);  n = n + 1'b1; end
              "v":      begin res[n] = mk_byte(8'd11); n = n + 1'b1; end
              ChBslash, ChSquote, ChDquote: begin
                res[n] = mk_byte(b);
                n      = n + 1'b1;
              end
              ChLf:     begin res[n] = mk_byte(ChLf);  n = n + 1'b1; end
              "z":      mode_d = ModeSkip;
              "x":      mode_d = ModeHex1;
              "u":      mode_d = ModeUbrace;
              default: begin
                if (b inside {[8'h30:8'h39]}) begin
                  esc_val_d = 32'(b - 8'h30);
                  dig_cnt_d = 4'd1;
                  mode_d    = ModeDec;
                end else begin
                  res[n] = mk_err(ErrBadEscape);
                  n      = n + 1'b1;
                  mode_d = ModeIdle;
                end
              end
            endcase
          end
          ModeSkip: begin
            if (!(b inside {8'h20, 8'h09, 8'h0d, 8'h0a, 8'h0b, 8'h0c})) begin
              mode_d   = ModeBody;
              run_body = 1'b1;
            end
          end
          ModeHex1: begin
            if (!hx[4]) begin
              res[n] = mk_err(ErrBadHex);
              n      = n + 1'b1;
              mode_d = ModeIdle;
            end else begin
              esc_val_d = 32'(hx[3:0]);
              mode_d    = ModeHex2;
            end
          end
          ModeHex2: begin
            if (!hx[4]) begin
              res[n] = mk_err(ErrBadHex);
              n      = n + 1'b1;
              mode_d = ModeIdle;
            end else begin
              res[n] = mk_byte({esc_val_q[3:0], hx[3:0]});
              n      = n + 1'b1;
              mode_d = ModeBody;
            end
          end
          ModeDec: begin
            if (b inside {[8'h30:8'h39]}) begin
              esc_val_d = 32'(dec_val);
              dig_cnt_d = dig_cnt_q + 1'b1;
              if (dig_cnt_q >= 4'd2) begin
                if (dec_val > 10'd255) begin
                  res[n] = mk_err(ErrDecRange);
                  n      = n + 1'b1;
                  mode_d = ModeIdle;
                end else begin
                  res[n] = mk_byte(dec_val[7:0]);
                  n      = n + 1'b1;
                  mode_d = ModeBody;
                end
              end
            end else begin
              // escape ends early, byte goes on as a body byte
              res[n]   = mk_byte(esc_val_q[7:0]);
              n        = n + 1'b1;
              mode_d   = ModeBody;
              run_body = 1'b1;
            end
          end
          ModeUbrace: begin
            if (b != "{") begin
              res[n] = mk_err(ErrUniForm);
              n      = n + 1'b1;
              mode_d = ModeIdle;
            end else begin
              esc_val_d = '0;
              dig_cnt_d = '0;
              mode_d    = ModeUdig;
            end
          end
          ModeUdig: begin
            if (b == "}") begin
              if (dig_cnt_q == '0) begin
                res[n] = mk_err(ErrUniForm);
                n      = n + 1'b1;
                mode_d = ModeIdle;
              end else if (esc_val_q[31]) begin
                res[n] = mk_err(ErrUniRange);
                n      = n + 1'b1;
                mode_d = ModeIdle;
              end else begin
                mode_d = ModeBody;
                res[n] = mk_byte(utf_lead);
                n      = n + 1'b1;
                // continuation bytes, most significant first
                for (int j = 4; j >= 0; j--) begin
                  if ((3'(j) + 3'd2) <= utf_len) begin
                    res[n] = mk_byte({2'b10, esc_val_q[6*j +: 6]});
                    n      = n + 1'b1;
                  end
                end
              end
            end else if (dig_cnt_q >= 4'd8 || !hx[4]) begin
              res[n] = mk_err(ErrUniForm);
              n      = n + 1'b1;
              mode_d = ModeIdle;
            end else begin
              esc_val_d = {esc_val_q[27:0], hx[3:0]};
              dig_cnt_d = dig_cnt_q + 1'b1;
            end
          end
          default: begin
            res[n] = mk_err(ErrUnterm);
            n      = n + 1'b1;
            mode_d = ModeIdle;
          end
        endcase
      end
      // plain body byte
      if (run_body) begin
        if (b == quote) begin
          res[n] = mk_close(cnt_ext[15:0]);
          n      = n + 1'b1;
          mode_d = ModeIdle;
        end else if (b == ChCr || b == ChLf) begin
          res[n] = mk_err(ErrRawBreak);
          n      = n + 1'b1;
          mode_d = ModeIdle;
        end else if (b == ChBslash) begin
          mode_d = ModeEsc;
        end else begin
          res[n] = mk_byte(b);
          n      = n + 1'b1;
        end
      end
    end
    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end
  end

  assign res_o.cnt  = n;
  assign res_o.item = res;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeIdle;
      dquote_q   <= 1'b0;
      esc_val_q  <= '0;
      dig_cnt_q  <= '0;
      byte_cnt_q <= '0;
    end else begin
      mode_q     <= mode_d;
      dquote_q   <= dquote_d;
      esc_val_q  <= esc_val_d;
      dig_cnt_q  <= dig_cnt_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

  // no results without a transfer into the decoder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go_i |-> res_o.cnt == '0)
    else $error("decoder produced results while idle");

  // an error always sends the machine back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.cnt != '0 && res_o.item[res_o.cnt - 1'b1].kind == KindError) |=>
      mode_q == ModeIdle)
    else $error("decoder not idle after error");

  // digit count stays within the longest escape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_cnt_q <= 4'd8)
    else $error("escape digit count out of range");

endmodule

// ----- design/qsed_fifo.sv -----
// ----------------------------------------------------------------------------
// qsed_fifo
// Result queue: takes a bundle of up to six results per cycle and hands
// them out one per transfer.
// ----------------------------------------------------------------------------
module qsed_fifo import qsed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  res_bundle_t push_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = PtrW + 1;

  out_item_t [FifoDepth-1:0] mem;
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= CntW'(FifoDepth - MaxRes));

  // pointer and fill bookkeeping
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(push_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage, bundle written at consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (ResCntW'(i) < push_i.cnt) begin
        mem[PtrW'(wr_ptr_q + PtrW'(i))] <= push_i.item[i];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != '0 |-> room_o)
    else $error("bundle pushed without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == '0) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count wrong after transfer out");

endmodule

// ----- design/quoted_string_escape_decoder_core.sv -----
// An input transfer passes the input register, then the result queue, before
// its first result is offered. Throughput: one source byte per cycle unless the
// input stalls; results leave one per cycle while out_stall_i is low.
// The input stalls while the 16-entry result queue has fewer than 6 free slots.
// Reset clears the literal state, the input valid flag and the result queue.
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder_core
// Top level: input register, escape decoder and result queue.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder_core import qsed_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        room;
  logic        go;
  res_bundle_t bundle;

  // decode the held byte once the queue can take a full bundle
  assign go         = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  qsed_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (in_item_q),
    .res_o  (bundle)
  );

  qsed_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (bundle),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
